// ----- hw/rtl/swgt_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swgt_pkg
// Shared types and constants of the sequence window gap tracker.
// ----------------------------------------------------------------------------
package swgt_pkg;

   localparam int SEQ_W  = 64;
   localparam int RTT_W  = 16;
   localparam int GAP_W  = 6;
   localparam int CMD_W  = 2;

   // desync threshold is max(GAP_FLOOR, GAP_OFFSET + rtt_ms / RTT_STEP_MS)
   localparam int GAP_FLOOR   = 8;
   localparam int GAP_OFFSET  = 2;
   localparam int RTT_STEP_MS = 50;

   typedef enum logic [CMD_W-1:0] {
      CMD_RECORD = 2'd0,
      CMD_QUERY  = 2'd1,
      CMD_CLEAR  = 2'd2
   } swgt_cmd_type;

   typedef struct packed {
      swgt_cmd_type     cmd;
      logic [SEQ_W-1:0] seq;
   } swgt_req_type;

   typedef struct packed {
      logic [GAP_W-1:0] gap_count;
      logic             desynced;
   } swgt_status_type;

endpackage
`default_nettype wire

// ----- hw/rtl/sequence_window_gap_tracker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sequence_window_gap_tracker
// Sliding anti-replay bitmap with gap count and desync flag.
// ----------------------------------------------------------------------------
// Each request carries a command on req_tuser (record, query, clear) and a
// sequence number plus round-trip estimate on req_tdata. The block keeps a
// WINDOW_BITS-wide bitmap anchored at the highest sequence recorded; every
// request returns exactly one response with the hit flag, the number of
// missing sequence numbers in the window after the request, and a desync flag
// that rises when that count exceeds max(8, 2 + floor(rtt_ms / 50)). One
// request is taken per clock cycle while req_tready is high; it lands in the
// input register at the accepting edge and passes through the window stage
// register and the output register, held back only while rsp_tready is low.
// The window update, which reads and writes the bitmap and anchor, sets
// that rate. Command code 3 leaves the window alone and answers with hit
// low. Back-pressure propagates stage by stage, so a stalled response never
// blocks requests until all three stages are full.
// ----------------------------------------------------------------------------
module sequence_window_gap_tracker #(
   parameter int WINDOW_BITS = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [79:0] req_tdata,   // [63:0] seq, [79:64] rtt_ms
   input  wire logic [1:0]  req_tuser,   // [1:0] cmd

   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata    // [0] hit, [6:1] gap_count, [7] desynced
);

   // --- stage handshakes: a stage opens when empty or when it drains -------
   logic rsp_open;
   logic s1_open;
   logic s0_open;
   logic fire;

   // --- input register -----------------------------------------------------
   logic                       s0_valid_ff;
   logic                       s0_valid_in;
   swgt_pkg::swgt_req_type     s0_req_ff;
   swgt_pkg::swgt_req_type     s0_req_in;
   logic [swgt_pkg::RTT_W-1:0] s0_rtt_ff;
   logic [swgt_pkg::RTT_W-1:0] s0_rtt_in;

   // --- window stage register ----------------------------------------------
   logic                       s1_valid_ff;
   logic                       s1_valid_in;
   logic                       s1_hit_ff;
   logic                       s1_hit_in;
   logic [swgt_pkg::RTT_W-1:0] s1_rtt_ff;
   logic [swgt_pkg::RTT_W-1:0] s1_rtt_in;
   logic [WINDOW_BITS-1:0]     s1_holes_ff;
   logic [WINDOW_BITS-1:0]     s1_holes_in;

   // --- output register ----------------------------------------------------
   logic                       rsp_valid_ff;
   logic                       rsp_valid_in;
   logic                       rsp_hit_ff;
   logic                       rsp_hit_in;
   swgt_pkg::swgt_status_type  rsp_status_ff;
   swgt_pkg::swgt_status_type  rsp_status_in;

   logic                       win_hit;
   logic [WINDOW_BITS-1:0]     win_holes;
   swgt_pkg::swgt_status_type  eval_status;

   assign rsp_open   = !rsp_valid_ff || rsp_tready;
   assign s1_open    = !s1_valid_ff || rsp_open;
   assign s0_open    = !s0_valid_ff || s1_open;
   assign req_tready = s0_open;
   assign fire       = s0_valid_ff && s1_open;

   // capture the request fields
   always_comb begin
      s0_valid_in = s0_valid_ff;
      s0_req_in   = s0_req_ff;
      s0_rtt_in   = s0_rtt_ff;
      if (s0_open) begin
         s0_valid_in = req_tvalid;
      end
      if (s0_open && req_tvalid) begin
         s0_req_in.cmd = swgt_pkg::swgt_cmd_type'(req_tuser);
         s0_req_in.seq = req_tdata[63:0];
         s0_rtt_in     = req_tdata[79:64];
      end
   end

   swgt_window #(
      .WINDOW_BITS (WINDOW_BITS)
   ) u_window (
      .clock (clock),
      .reset (reset),
      .fire  (fire),
      .req   (s0_req_ff),
      .hit   (win_hit),
      .holes (win_holes)
   );

   // hold the window snapshot until the output register takes it
   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_hit_in   = s1_hit_ff;
      s1_rtt_in   = s1_rtt_ff;
      s1_holes_in = s1_holes_ff;
      if (s1_open) begin
         s1_valid_in = s0_valid_ff;
      end
      if (fire) begin
         s1_hit_in   = win_hit;
         s1_rtt_in   = s0_rtt_ff;
         s1_holes_in = win_holes;
      end
   end

   swgt_gap_eval #(
      .WINDOW_BITS (WINDOW_BITS)
   ) u_gap_eval (
      .holes  (s1_holes_ff),
      .rtt_ms (s1_rtt_ff),
      .status (eval_status)
   );

   // load the response when the output register drains or is empty
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_hit_in    = rsp_hit_ff;
      rsp_status_in = rsp_status_ff;
      if (rsp_open) begin
         rsp_valid_in = s1_valid_ff;
      end
      if (rsp_open && s1_valid_ff) begin
         rsp_hit_in    = s1_hit_ff;
         rsp_status_in = eval_status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff  <= 1'b0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff  <= s0_valid_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s0_req_ff     <= s0_req_in;
      s0_rtt_ff     <= s0_rtt_in;
      s1_hit_ff     <= s1_hit_in;
      s1_rtt_ff     <= s1_rtt_in;
      s1_holes_ff   <= s1_holes_in;
      rsp_hit_ff    <= rsp_hit_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_status_ff.desynced, rsp_status_ff.gap_count, rsp_hit_ff};

`ifndef SYNTHESIS
   // a request applied to the window always lands in the window stage
   assert property (@(posedge clock) disable iff (reset) fire |=> s1_valid_ff)
      else $error("window update lost its request");

   // a stalled window-stage entry must not vanish
   assert property (@(posedge clock) disable iff (reset)
                    s1_valid_ff && !rsp_open |=> s1_valid_ff)
      else $error("window stage dropped a held entry");

   // the anchor itself is never a missing number
   assert property (@(posedge clock) disable iff (reset) s1_valid_ff |-> !s1_holes_ff[0])
      else $error("anchor position reported missing");

   // desync needs more gaps than the fixed floor
   assert property (@(posedge clock) disable iff (reset)
                    rsp_valid_ff && rsp_status_ff.desynced |->
                    rsp_status_ff.gap_count > swgt_pkg::GAP_W'(swgt_pkg::GAP_FLOOR))
      else $error("desync flagged below gap floor");
`endif

endmodule
`default_nettype wire

// ----- hw/rtl/swgt_window.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swgt_window
// Window state (highest sequence and seen bitmap) and the record, query and
// clear update; reports the hit flag and the missing positions after update.
// ----------------------------------------------------------------------------
module swgt_window #(
   parameter int WINDOW_BITS = 64
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     fire,
   input  wire swgt_pkg::swgt_req_type   req,
   output logic                          hit,
   output logic [WINDOW_BITS-1:0]        holes
);

   localparam int IDX_W = $clog2(WINDOW_BITS);

   logic [swgt_pkg::SEQ_W-1:0] highest_ff;
   logic [swgt_pkg::SEQ_W-1:0] highest_in;
   logic [WINDOW_BITS-1:0]     bitmap_ff;
   logic [WINDOW_BITS-1:0]     bitmap_in;

   logic                       ahead;
   logic                       behind;
   logic [swgt_pkg::SEQ_W-1:0] delta;
   logic [swgt_pkg::SEQ_W-1:0] age;
   logic                       delta_in_win;
   logic                       age_in_win;
   logic [IDX_W-1:0]           age_idx;
   logic [WINDOW_BITS-1:0]     shifted;

   assign ahead        = req.seq > highest_ff;
   assign behind       = req.seq < highest_ff;
   assign delta        = req.seq - highest_ff;
   assign age          = highest_ff - req.seq;
   assign delta_in_win = delta < swgt_pkg::SEQ_W'(WINDOW_BITS);
   assign age_in_win   = age < swgt_pkg::SEQ_W'(WINDOW_BITS);
   assign age_idx      = age[IDX_W-1:0];
   assign shifted      = (bitmap_ff << delta[IDX_W-1:0]) | WINDOW_BITS'(1);

   always_comb begin
      highest_in = highest_ff;
      bitmap_in  = bitmap_ff;
      hit        = 1'b0;
      if (fire) begin
         unique case (req.cmd)
            swgt_pkg::CMD_RECORD: begin
               if (ahead) begin
                  // advance the anchor; a long jump restarts the window
                  highest_in = req.seq;
                  bitmap_in  = delta_in_win ? shifted : WINDOW_BITS'(1);
                  hit        = 1'b1;
               end else if (behind && age_in_win) begin
                  hit                = !bitmap_ff[age_idx];
                  bitmap_in[age_idx] = 1'b1;
               end
            end
            swgt_pkg::CMD_QUERY: begin
               if (req.seq == highest_ff) begin
                  hit = highest_ff != '0;
               end else if (behind && age_in_win) begin
                  hit = bitmap_ff[age_idx];
               end
            end
            swgt_pkg::CMD_CLEAR: begin
               highest_in = '0;
               bitmap_in  = '0;
            end
            default: begin
            end
         endcase
      end
   end

   // missing positions: unseen ages 1 .. WINDOW_BITS-1 with a sequence number above zero
   always_comb begin
      for (int i = 0; i < WINDOW_BITS; i++) begin
         holes[i] = (i != 0) && !bitmap_in[i] &&
                    (highest_in > swgt_pkg::SEQ_W'(i));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         highest_ff <= '0;
         bitmap_ff  <= '0;
      end else begin
         highest_ff <= highest_in;
         bitmap_ff  <= bitmap_in;
      end
   end

endmodule
`default_nettype wire

// ----- hw/rtl/swgt_gap_eval.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swgt_gap_eval
// Count missing positions and compare against the round-trip threshold.
// ----------------------------------------------------------------------------
module swgt_gap_eval #(
   parameter int WINDOW_BITS = 64
) (
   input  wire logic [WINDOW_BITS-1:0]       holes,
   input  wire logic [swgt_pkg::RTT_W-1:0]   rtt_ms,
   output swgt_pkg::swgt_status_type         status
);

   localparam int GROUPS = (WINDOW_BITS + 7) / 8;
   localparam int PAD_W  = GROUPS * 8;

   logic [PAD_W-1:0]           padded;
   logic [3:0]                 group_cnt [GROUPS];
   logic [swgt_pkg::GAP_W-1:0] total;
   logic [swgt_pkg::RTT_W-1:0] excess;
   logic [swgt_pkg::RTT_W-1:0] rtt_bound;

   assign padded = PAD_W'(holes);

   // count per byte, then add the byte counts
   always_comb begin
      for (int g = 0; g < GROUPS; g++) begin
         group_cnt[g] = '0;
         for (int b = 0; b < 8; b++) begin
            group_cnt[g] = group_cnt[g] + 4'(padded[g*8 + b]);
         end
      end
   end

   always_comb begin
      total = '0;
      for (int g = 0; g < GROUPS; g++) begin
         total = total + swgt_pkg::GAP_W'(group_cnt[g]);
      end
   end

   // gaps > OFFSET + floor(rtt / STEP)  <=>  rtt < STEP * (gaps - OFFSET)
   assign excess    = swgt_pkg::RTT_W'(total) - swgt_pkg::RTT_W'(swgt_pkg::GAP_OFFSET);
   assign rtt_bound = excess * swgt_pkg::RTT_W'(swgt_pkg::RTT_STEP_MS);

   assign status.gap_count = total;
   assign status.desynced  = (total > swgt_pkg::GAP_W'(swgt_pkg::GAP_FLOOR)) &&
                             (rtt_ms < rtt_bound);

endmodule
`default_nettype wire
